// File: rtl/core/tilt_complementary_filter_defines.svh
// Assertion macros shared by the tilt filter RTL.
// Needs i_clk and i_rst_n in the scope where a macro is used.
`ifndef TILT_COMPLEMENTARY_FILTER_DEFINES_SVH
`define TILT_COMPLEMENTARY_FILTER_DEFINES_SVH

// Checks that the consequent holds in the same cycle as the antecedent.
`define TCF_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Checks that the consequent holds in the cycle after the antecedent.
`define TCF_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/core/tcf_pkg.sv
// Shared constants, types and the arctangent table of the tilt filter.
// Used by every module in rtl/core; depends on nothing.
package tcf_pkg;

    localparam int unsigned FILTER_WEIGHT     = 65274;
    localparam int unsigned CORDIC_ITERATIONS = 16;
    localparam int unsigned TABLE_LEN         = 24;
    localparam int unsigned CORDIC_STEPS      =
        (CORDIC_ITERATIONS > TABLE_LEN) ? TABLE_LEN : CORDIC_ITERATIONS;

    localparam int unsigned W_BITS  = 16;
    localparam logic [W_BITS-1:0] W_VALUE = W_BITS'(FILTER_WEIGHT);
    localparam logic [W_BITS:0]   W_COMPL = (W_BITS + 1)'(65536 - FILTER_WEIGHT);

    localparam int unsigned STEP_W = 5;
    localparam int unsigned XY_W   = 28;
    localparam int unsigned Z_W    = 27;
    localparam int unsigned ANG_W  = Z_W - 8;
    localparam int unsigned P_W    = 27;
    localparam int unsigned B_W    = 46;

    localparam int signed HALF_TURN = 180 * 65536;

    localparam int unsigned NUM_REGS = 8;
    localparam logic [2:0] REG_GYRO_X_BIAS   = 3'd0;
    localparam logic [2:0] REG_GYRO_Y_BIAS   = 3'd1;
    localparam logic [2:0] REG_VERTEX_ACC_X  = 3'd2;
    localparam logic [2:0] REG_VERTEX_ACC_Y  = 3'd3;
    localparam logic [2:0] REG_VERTEX_ACC_Z  = 3'd4;
    localparam logic [2:0] REG_EDGE_ACC_X    = 3'd5;
    localparam logic [2:0] REG_EDGE_ACC_Y    = 3'd6;
    localparam logic [2:0] REG_EDGE_ACC_Z    = 3'd7;

    typedef enum logic [5:0] {
        ST_IDLE    = 6'b000001,
        ST_CORD_Y  = 6'b000010,
        ST_CORD_X  = 6'b000100,
        ST_BLEND_Y = 6'b001000,
        ST_BLEND_X = 6'b010000,
        ST_FINISH  = 6'b100000
    } t_state;

    // Arctangent of 2^-i in 1/65536 degree.
    function automatic logic signed [Z_W-1:0] atan_entry(input logic [STEP_W-1:0] idx);
        logic [21:0] v;
        unique case (idx)
            5'd0:    v = 22'd2949120;
            5'd1:    v = 22'd1740967;
            5'd2:    v = 22'd919879;
            5'd3:    v = 22'd466945;
            5'd4:    v = 22'd234379;
            5'd5:    v = 22'd117304;
            5'd6:    v = 22'd58666;
            5'd7:    v = 22'd29335;
            5'd8:    v = 22'd14668;
            5'd9:    v = 22'd7334;
            5'd10:   v = 22'd3667;
            5'd11:   v = 22'd1833;
            5'd12:   v = 22'd917;
            5'd13:   v = 22'd458;
            5'd14:   v = 22'd229;
            5'd15:   v = 22'd115;
            5'd16:   v = 22'd57;
            5'd17:   v = 22'd29;
            5'd18:   v = 22'd14;
            5'd19:   v = 22'd7;
            5'd20:   v = 22'd4;
            5'd21:   v = 22'd2;
            5'd22:   v = 22'd1;
            default: v = 22'd0;
        endcase
        return $signed({{(Z_W-22){1'b0}}, v});
    endfunction

endpackage

// File: rtl/core/tcf_cordic.sv
// Iterative CORDIC atan2 in vectoring mode, one micro-rotation per cycle.
// Depends on tcf_pkg for widths, step count and the arctangent table.
module tcf_cordic import tcf_pkg::*; (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_start,
    input  logic signed [15:0]      i_y,
    input  logic signed [16:0]      i_x,
    output logic                    o_done,
    output logic signed [ANG_W-1:0] o_angle
);

    logic                    r_busy, n_busy;
    logic                    r_fin, n_fin;
    logic                    r_done, n_done;
    logic [STEP_W-1:0]       r_step, n_step;
    logic signed [XY_W-1:0]  r_x, n_x;
    logic signed [XY_W-1:0]  r_y, n_y;
    logic signed [Z_W-1:0]   r_z, n_z;
    logic signed [ANG_W-1:0] r_angle, n_angle;
    logic signed [XY_W-1:0]  x0, y0, xs, ys;
    logic signed [Z_W-1:0]   z_rnd;

    always_comb begin
        x0      = XY_W'(i_x) <<< 8;
        y0      = XY_W'(i_y) <<< 8;
        xs      = r_x >>> r_step;
        ys      = r_y >>> r_step;
        z_rnd   = r_z + Z_W'(128);
        n_busy  = r_busy;
        n_fin   = 1'b0;
        n_done  = 1'b0;
        n_step  = r_step;
        n_x     = r_x;
        n_y     = r_y;
        n_z     = r_z;
        n_angle = r_angle;
        if (r_fin) begin
            n_angle = z_rnd[Z_W-1:8];
            n_done  = 1'b1;
        end else if (r_busy) begin
            if (r_y > 0) begin
                n_x = r_x + ys;
                n_y = r_y - xs;
                n_z = r_z + atan_entry(r_step);
            end else begin
                n_x = r_x - ys;
                n_y = r_y + xs;
                n_z = r_z - atan_entry(r_step);
            end
            n_step = r_step + STEP_W'(1);
            if (r_step == STEP_W'(CORDIC_STEPS - 1)) begin
                n_busy = 1'b0;
                n_fin  = 1'b1;
            end
        end else if (i_start) begin
            if (i_x == 0 && i_y == 0) begin
                n_angle = '0;
                n_done  = 1'b1;
            end else begin
                n_busy = 1'b1;
                n_step = '0;
                if (i_x < 0) begin
                    n_x = -x0;
                    n_y = -y0;
                    n_z = (i_y >= 0) ? Z_W'(HALF_TURN) : -Z_W'(HALF_TURN);
                end else begin
                    n_x = x0;
                    n_y = y0;
                    n_z = '0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_fin  <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_fin  <= n_fin;
            r_done <= n_done;
        end
        r_step  <= n_step;
        r_x     <= n_x;
        r_y     <= n_y;
        r_z     <= n_z;
        r_angle <= n_angle;
    end

    assign o_done  = r_done;
    assign o_angle = r_angle;

endmodule

// File: rtl/core/tcf_blend.sv
// Complementary blend of one axis: the gyro path is weighted by a bit-serial
// shift-and-add multiplier, one weight bit per cycle. Depends on tcf_pkg.
module tcf_blend import tcf_pkg::*; (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_start,
    input  logic signed [16:0]      i_tilt,
    input  logic signed [15:0]      i_rate,
    input  logic [7:0]              i_dt,
    input  logic signed [ANG_W-1:0] i_acc,
    output logic                    o_done,
    output logic signed [16:0]      o_result
);

    logic                    r_busy, n_busy;
    logic                    r_fin, n_fin;
    logic                    r_done, n_done;
    logic [4:0]              r_cnt, n_cnt;
    logic [W_BITS-1:0]       r_w, n_w;
    logic signed [B_W-1:0]   r_pp, n_pp;
    logic signed [B_W-1:0]   r_b, n_b;
    logic signed [16:0]      r_result, n_result;
    logic signed [24:0]      rate_dt;
    logic signed [P_W-1:0]   p;
    logic signed [36:0]      acc_term;
    logic signed [B_W-1:0]   b_rnd;
    logic signed [B_W-25:0]  q;

    always_comb begin
        rate_dt  = i_rate * $signed({1'b0, i_dt});
        p        = (P_W'(i_tilt) <<< 8) + P_W'(rate_dt);
        acc_term = i_acc * $signed({1'b0, W_COMPL});
        b_rnd    = r_b + B_W'(64'sd1 <<< 23);
        q        = b_rnd[B_W-1:24];
        n_busy   = r_busy;
        n_fin    = 1'b0;
        n_done   = 1'b0;
        n_cnt    = r_cnt;
        n_w      = r_w;
        n_pp     = r_pp;
        n_b      = r_b;
        n_result = r_result;
        if (r_fin) begin
            priority if (q > 65535) begin
                n_result = 17'sd65535;
            end else if (q < -65536) begin
                n_result = -17'sd65536;
            end else begin
                n_result = q[16:0];
            end
            n_done = 1'b1;
        end else if (r_busy) begin
            if (r_w[0]) begin
                n_b = r_b + r_pp;
            end
            n_pp  = r_pp <<< 1;
            n_w   = r_w >> 1;
            n_cnt = r_cnt + 5'd1;
            if (r_cnt == 5'(W_BITS - 1)) begin
                n_busy = 1'b0;
                n_fin  = 1'b1;
            end
        end else if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = '0;
            n_w    = W_VALUE;
            n_pp   = B_W'(p);
            n_b    = B_W'(acc_term) <<< 8;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_fin  <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_fin  <= n_fin;
            r_done <= n_done;
        end
        r_cnt    <= n_cnt;
        r_w      <= n_w;
        r_pp     <= n_pp;
        r_b      <= n_b;
        r_result <= n_result;
    end

    assign o_done   = r_done;
    assign o_result = r_result;

endmodule

// File: rtl/core/tilt_complementary_filter.sv
// Tilt estimator: one inertial sample in, one filtered X/Y tilt and balance
// flags out. Each accepted sample runs two CORDIC atan2 passes in the shared
// iterative unit (cut short when both operands are zero), then two bit-serial
// blends, and then loads the output register. A new sample is taken once the
// previous one has been loaded into the output register, so the block cannot
// take a new sample before it is through with the last one; a result that is
// not taken holds the block in its final state. Configuration writes are
// accepted every cycle.
module tilt_complementary_filter import tcf_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [3:0]         i_cfg_index,
    input  logic [15:0]        i_cfg_data,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic signed [15:0] i_gyro_x,
    input  logic signed [15:0] i_gyro_y,
    input  logic signed [15:0] i_acc_x,
    input  logic signed [15:0] i_acc_y,
    input  logic signed [15:0] i_acc_z,
    input  logic [7:0]         i_dt_ms,
    output logic               o_valid,
    input  logic               i_ready,
    output logic signed [16:0] o_angle_x,
    output logic signed [16:0] o_angle_y,
    output logic               o_on_vertex,
    output logic               o_on_edge,
    output logic               o_not_balanced
);

`include "tilt_complementary_filter_defines.svh"

    t_state                  r_state, n_state;
    logic [15:0]             r_cfg [NUM_REGS];
    logic                    r_cstart, n_cstart;
    logic                    r_bstart, n_bstart;
    logic signed [15:0]      r_gxc, r_gyc, r_axc, r_ayc, r_azc;
    logic [7:0]              r_dt;
    logic                    r_small, r_mid;
    logic signed [ANG_W-1:0] r_ang_x, r_ang_y;
    logic signed [16:0]      r_bx, r_by;
    logic signed [16:0]      r_tilt_x, r_tilt_y;
    logic                    r_vflag, r_eflag;
    logic                    r_ovalid;
    logic signed [16:0]      r_out_x, r_out_y;
    logic                    r_out_v, r_out_e;

    logic                    in_acc;
    logic signed [16:0]      abs_ax;
    logic                    small_ax;
    logic [2:0]              base;
    logic signed [15:0]      c_y;
    logic signed [16:0]      c_x;
    logic                    c_done;
    logic signed [ANG_W-1:0] c_angle;
    logic signed [16:0]      b_tilt;
    logic signed [15:0]      b_rate;
    logic signed [ANG_W-1:0] b_acc;
    logic                    b_done;
    logic signed [16:0]      b_result;
    logic signed [16:0]      sat_ax, sat_ay;
    logic                    tilted, near_x, near_y, edge_x, latch_v, latch_e, fin_go;

    assign o_cfg_ready = 1'b1;
    assign o_ready     = (r_state == ST_IDLE);
    assign in_acc      = i_valid && o_ready;

    always_comb begin
        abs_ax   = i_acc_x[15] ? -17'(i_acc_x) : 17'(i_acc_x);
        small_ax = (abs_ax < 17'sd2000);
        base     = small_ax ? REG_VERTEX_ACC_X : REG_EDGE_ACC_X;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NUM_REGS; k++) begin
                r_cfg[k] <= '0;
            end
        end else if (i_cfg_valid && o_cfg_ready && !i_cfg_index[3]) begin
            r_cfg[i_cfg_index[2:0]] <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_gxc   <= i_gyro_x - $signed(r_cfg[REG_GYRO_X_BIAS]);
            r_gyc   <= i_gyro_y - $signed(r_cfg[REG_GYRO_Y_BIAS]);
            r_axc   <= i_acc_x - $signed(r_cfg[base]);
            r_ayc   <= i_acc_y - $signed(r_cfg[base + 3'd1]);
            r_azc   <= i_acc_z - $signed(r_cfg[base + 3'd2]);
            r_dt    <= i_dt_ms;
            r_small <= small_ax;
            r_mid   <= (abs_ax > 17'sd7000) && (abs_ax < 17'sd10000);
        end
        if (c_done && r_state == ST_CORD_Y) begin
            r_ang_y <= c_angle;
        end
        if (c_done && r_state == ST_CORD_X) begin
            r_ang_x <= -c_angle;
        end
        if (b_done && r_state == ST_BLEND_Y) begin
            r_by <= b_result;
        end
        if (b_done && r_state == ST_BLEND_X) begin
            r_bx <= b_result;
        end
    end

    assign c_y = (r_state == ST_CORD_Y) ? r_axc : r_ayc;
    assign c_x = -17'(r_azc);

    tcf_cordic u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_cstart),
        .i_y     (c_y),
        .i_x     (c_x),
        .o_done  (c_done),
        .o_angle (c_angle)
    );

    always_comb begin
        if (r_state == ST_BLEND_Y) begin
            b_tilt = r_tilt_y;
            b_rate = r_gyc;
            b_acc  = r_ang_y;
        end else begin
            b_tilt = r_tilt_x;
            b_rate = r_gxc;
            b_acc  = r_ang_x;
        end
    end

    tcf_blend u_blend (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (r_bstart),
        .i_tilt   (b_tilt),
        .i_rate   (b_rate),
        .i_dt     (r_dt),
        .i_acc    (b_acc),
        .o_done   (b_done),
        .o_result (b_result)
    );

    always_comb begin
        sat_ax = (r_ang_x > 65535) ? 17'sd65535 :
                 (r_ang_x < -65536) ? -17'sd65536 : r_ang_x[16:0];
        sat_ay = (r_ang_y > 65535) ? 17'sd65535 :
                 (r_ang_y < -65536) ? -17'sd65536 : r_ang_y[16:0];
        tilted = (r_bx > 17'sd1792) || (r_bx < -17'sd1792) ||
                 (r_by > 17'sd1792) || (r_by < -17'sd1792);
        near_x = (r_ang_x <= 102) && (r_ang_x >= -102);
        near_y = (r_ang_y <= 102) && (r_ang_y >= -102);
        edge_x = (r_ang_x <= 76) && (r_ang_x >= -76);
        latch_v = r_small && near_x && near_y && !r_vflag && !r_eflag;
        latch_e = r_mid && edge_x && !r_vflag && !r_eflag;
        fin_go  = (r_state == ST_FINISH) && (!r_ovalid || i_ready);
    end

    always_comb begin
        n_state  = r_state;
        n_cstart = 1'b0;
        n_bstart = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    n_state  = ST_CORD_Y;
                    n_cstart = 1'b1;
                end
            end
            ST_CORD_Y: begin
                if (c_done) begin
                    n_state  = ST_CORD_X;
                    n_cstart = 1'b1;
                end
            end
            ST_CORD_X: begin
                if (c_done) begin
                    n_state  = ST_BLEND_Y;
                    n_bstart = 1'b1;
                end
            end
            ST_BLEND_Y: begin
                if (b_done) begin
                    n_state  = ST_BLEND_X;
                    n_bstart = 1'b1;
                end
            end
            ST_BLEND_X: begin
                if (b_done) begin
                    n_state = ST_FINISH;
                end
            end
            ST_FINISH: begin
                if (fin_go) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_cstart <= 1'b0;
            r_bstart <= 1'b0;
            r_tilt_x <= '0;
            r_tilt_y <= '0;
            r_vflag  <= 1'b0;
            r_eflag  <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_cstart <= n_cstart;
            r_bstart <= n_bstart;
            if (fin_go) begin
                r_ovalid <= 1'b1;
                priority if (latch_v) begin
                    r_tilt_x <= sat_ax;
                    r_tilt_y <= sat_ay;
                    r_vflag  <= 1'b1;
                end else if (latch_e) begin
                    r_tilt_x <= sat_ax;
                    r_tilt_y <= sat_ay;
                    r_eflag  <= 1'b1;
                end else begin
                    r_tilt_x <= r_bx;
                    r_tilt_y <= r_by;
                    if (tilted && r_vflag) begin
                        r_vflag <= 1'b0;
                    end else if (tilted && r_eflag) begin
                        r_eflag <= 1'b0;
                    end
                end
            end else if (i_ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (fin_go) begin
            r_out_x <= (latch_v || latch_e) ? sat_ax : r_bx;
            r_out_y <= (latch_v || latch_e) ? sat_ay : r_by;
            r_out_v <= latch_v || (r_vflag && !tilted);
            r_out_e <= latch_e || (r_eflag && !(tilted && !r_vflag));
        end
    end

    assign o_valid        = r_ovalid;
    assign o_angle_x      = r_out_x;
    assign o_angle_y      = r_out_y;
    assign o_on_vertex    = r_out_v;
    assign o_on_edge      = r_out_e;
    assign o_not_balanced = !r_out_v && !r_out_e;

    `TCF_ASSERT_SAME(a_flags_exclusive, 1'b1, !(r_vflag && r_eflag), "both balance flags set")
    `TCF_ASSERT_NEXT(a_accept_leaves_idle, in_acc, r_state == ST_CORD_Y, "accept did not start CORDIC")
    `TCF_ASSERT_SAME(a_cordic_done_state, c_done, r_state == ST_CORD_Y || r_state == ST_CORD_X, "CORDIC result outside its phase")
    `TCF_ASSERT_SAME(a_blend_done_state, b_done, r_state == ST_BLEND_Y || r_state == ST_BLEND_X, "blend result outside its phase")

endmodule
